/* rtl/rth_pkg.sv */
// rth_pkg: shared constants and types of the ray / triangle hit test
// used by rth_div, ray_triangle_hit_test and rth_checker; no dependencies
`default_nettype none

package rth_pkg;

    // default coordinate format, signed Q11.12
    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_FRAC_BITS  = 12;

    // barycentric weights are unsigned Q0.16 with one extra bit for 1.0
    localparam int WEIGHT_FRAC = 16;
    localparam int WEIGHT_BITS = WEIGHT_FRAC + 1;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << WEIGHT_FRAC;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Z     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_X        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_Y        = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_Z        = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_DISTANCE = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_DISTANCE = 3'd7;

    // status of one divider lane
    typedef struct packed {
        logic ovf;      // quotient does not fit the lane
        logic rem_nz;   // nonzero remainder
    } rth_div_stat_t;

    // control bits that travel beside the divider lanes
    typedef struct packed {
        logic valid;
        logic pre_hit;  // determinant and weight tests passed
        logic t_neg;    // distance numerator is negative
    } rth_side_t;

endpackage

`default_nettype wire

/* rtl/rth_div.sv */
// rth_div: pipelined restoring divider, one quotient bit per stage
// depends on rth_pkg for the status struct
`default_nettype none

module rth_div
    import rth_pkg::*;
#(
    parameter int NW = 96,
    parameter int DW = 76,
    parameter int QB = 24
)
(
    input  wire logic          clk,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [QB-1:0] quo,
    output rth_div_stat_t      stat
);

    localparam int WW = ((NW > DW + QB) ? NW : DW + QB) + 1;

    logic [WW-1:0] r_in    [QB];
    logic [WW-1:0] d_in    [QB];
    logic [QB-1:0] q_in    [QB];
    logic          ovf_in  [QB];
    logic [WW-1:0] r_next  [QB];
    logic [QB-1:0] q_next  [QB];
    logic [WW-1:0] r_reg   [QB];
    logic [WW-1:0] d_reg   [QB];
    logic [QB-1:0] q_reg   [QB];
    logic          ovf_reg [QB];

    // first stage also flags a quotient of more than QB bits
    assign r_in[0]   = WW'(num);
    assign d_in[0]   = WW'(den);
    assign q_in[0]   = '0;
    assign ovf_in[0] = (WW'(num) >= (WW'(den) << QB));

    for (genvar i = 0; i < QB; i++)
    begin : g_stage
        if (i > 0)
        begin : g_link
            assign r_in[i]   = r_reg[i-1];
            assign d_in[i]   = d_reg[i-1];
            assign q_in[i]   = q_reg[i-1];
            assign ovf_in[i] = ovf_reg[i-1];
        end

        // trial subtract of the divisor at this bit weight
        logic [WW-1:0] shifted;
        logic          ge;
        assign shifted   = d_in[i] << (QB - 1 - i);
        assign ge        = (r_in[i] >= shifted);
        assign r_next[i] = ge ? (r_in[i] - shifted) : r_in[i];
        assign q_next[i] = {q_in[i][QB-2:0], ge};

        always_ff @(posedge clk)
        begin
            r_reg[i]   <= r_next[i];
            d_reg[i]   <= d_in[i];
            q_reg[i]   <= q_next[i];
            ovf_reg[i] <= ovf_in[i];
        end
    end

    assign quo         = q_reg[QB-1];
    assign stat.ovf    = ovf_reg[QB-1];
    assign stat.rem_nz = |r_reg[QB-1];

endmodule

`default_nettype wire

/* rtl/ray_triangle_hit_test.sv */
// ray_triangle_hit_test: fully pipelined Moller-Trumbore ray / triangle test
// depends on rth_pkg and rth_div
//
// Usage: the ray (origin, direction, distance window) sits in eight
// registers written over the cfg channel (cfg_valid / cfg_ready, cfg_index,
// cfg_data); cfg_ready is always high. Write them only while no triangle is
// in flight. A triangle transaction is taken at each rising edge with start
// high and busy low; busy stays low, so one triangle enters every cycle.
// Each triangle yields one result: done is high for exactly one cycle with
// hit, distance, weight_one and weight_two; on a miss all four are zero.
// Pipeline: eight stages of edge, cross and dot product arithmetic (products
// split into halves of about 25 x 25 bits), then three parallel restoring
// dividers that resolve one quotient bit per stage, then the output register.
// Throughput: one triangle per cycle, results in order of entry.
// Reset clears the pipeline valid bits and loads the ray registers with
// origin 0, direction (0, 0, 1.0), window [0, most positive]. The receiver
// cannot stall; a result not taken in its cycle is gone.
`default_nettype none

module ray_triangle_hit_test
    import rth_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // triangle channel
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic signed [COORD_BITS-1:0] v0_x,
    input  wire logic signed [COORD_BITS-1:0] v0_y,
    input  wire logic signed [COORD_BITS-1:0] v0_z,
    input  wire logic signed [COORD_BITS-1:0] v1_x,
    input  wire logic signed [COORD_BITS-1:0] v1_y,
    input  wire logic signed [COORD_BITS-1:0] v1_z,
    input  wire logic signed [COORD_BITS-1:0] v2_x,
    input  wire logic signed [COORD_BITS-1:0] v2_y,
    input  wire logic signed [COORD_BITS-1:0] v2_z,
    // result channel
    output logic                              done,
    output logic                              hit,
    output logic signed      [COORD_BITS-1:0] distance,
    output logic             [WEIGHT_BITS-1:0] weight_one,
    output logic             [WEIGHT_BITS-1:0] weight_two,
    // configuration channel
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic        [COORD_BITS-1:0] cfg_data
);

    localparam int C    = COORD_BITS;
    localparam int E    = C + 1;                 // edge and offset width
    localparam int PW   = 2 * E;                 // cross product width
    localparam int L    = C + 1;                 // low split of a cross component
    localparam int DW   = 3 * C + 4;             // dot product width
    localparam int SH   = (FRAC_BITS > WEIGHT_FRAC) ? FRAC_BITS : WEIGHT_FRAC;
    localparam int NW   = DW + SH;               // dividend width
    localparam int DIVQ = (C > WEIGHT_BITS) ? C : WEIGHT_BITS;
    localparam int TW   = DIVQ + 2;              // signed distance compare width

    localparam int DOT_DET = 0;
    localparam int DOT_N1  = 1;
    localparam int DOT_N2  = 2;
    localparam int DOT_NT  = 3;

    // ---------------- configuration registers
    logic signed [C-1:0] org_reg [3];
    logic signed [C-1:0] dir_reg [3];
    logic signed [C-1:0] min_distance_reg;
    logic signed [C-1:0] max_distance_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0]       <= '0;
            org_reg[1]       <= '0;
            org_reg[2]       <= '0;
            dir_reg[0]       <= '0;
            dir_reg[1]       <= '0;
            dir_reg[2]       <= C'(1) << FRAC_BITS;
            min_distance_reg <= '0;
            max_distance_reg <= {1'b0, {(C-1){1'b1}}};
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:     org_reg[0]       <= cfg_data;
                CFG_ORIGIN_Y:     org_reg[1]       <= cfg_data;
                CFG_ORIGIN_Z:     org_reg[2]       <= cfg_data;
                CFG_DIR_X:        dir_reg[0]       <= cfg_data;
                CFG_DIR_Y:        dir_reg[1]       <= cfg_data;
                CFG_DIR_Z:        dir_reg[2]       <= cfg_data;
                CFG_MIN_DISTANCE: min_distance_reg <= cfg_data;
                CFG_MAX_DISTANCE: max_distance_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // ---------------- pipeline valid bits, stages 1 to 7
    logic vld_reg [7];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 7; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int s = 1; s < 7; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // ---------------- stage 1: edges and origin offset
    logic signed [C-1:0] v0 [3];
    logic signed [C-1:0] v1 [3];
    logic signed [C-1:0] v2 [3];
    logic signed [E-1:0] dir_e [3];
    logic signed [E-1:0] e1_a_reg [3];
    logic signed [E-1:0] e2_a_reg [3];
    logic signed [E-1:0] q_a_reg  [3];

    assign v0[0] = v0_x;
    assign v0[1] = v0_y;
    assign v0[2] = v0_z;
    assign v1[0] = v1_x;
    assign v1[1] = v1_y;
    assign v1[2] = v1_z;
    assign v2[0] = v2_x;
    assign v2[1] = v2_y;
    assign v2[2] = v2_z;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            dir_e[k] = E'(dir_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1_a_reg[k] <= E'(v1[k]) - E'(v0[k]);
            e2_a_reg[k] <= E'(v2[k]) - E'(v0[k]);
            q_a_reg[k]  <= E'(org_reg[k]) - E'(v0[k]);
        end
    end

    // ---------------- stage 2: cross product terms, s1 = dir x e2, s2 = q x e1
    logic signed [PW-1:0] pa1_reg [3];
    logic signed [PW-1:0] pb1_reg [3];
    logic signed [PW-1:0] pa2_reg [3];
    logic signed [PW-1:0] pb2_reg [3];
    logic signed [E-1:0]  e1_b_reg [3];
    logic signed [E-1:0]  e2_b_reg [3];
    logic signed [E-1:0]  q_b_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            pa1_reg[k] <= dir_e[(k+1)%3] * e2_a_reg[(k+2)%3];
            pb1_reg[k] <= dir_e[(k+2)%3] * e2_a_reg[(k+1)%3];
            pa2_reg[k] <= q_a_reg[(k+1)%3] * e1_a_reg[(k+2)%3];
            pb2_reg[k] <= q_a_reg[(k+2)%3] * e1_a_reg[(k+1)%3];
            e1_b_reg[k] <= e1_a_reg[k];
            e2_b_reg[k] <= e2_a_reg[k];
            q_b_reg[k]  <= q_a_reg[k];
        end
    end

    // ---------------- stage 3: cross product components
    logic signed [PW-1:0] s1_reg [3];
    logic signed [PW-1:0] s2_reg [3];
    logic signed [E-1:0]  e1_c_reg [3];
    logic signed [E-1:0]  e2_c_reg [3];
    logic signed [E-1:0]  q_c_reg  [3];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            s1_reg[k]   <= pa1_reg[k] - pb1_reg[k];
            s2_reg[k]   <= pa2_reg[k] - pb2_reg[k];
            e1_c_reg[k] <= e1_b_reg[k];
            e2_c_reg[k] <= e2_b_reg[k];
            q_c_reg[k]  <= q_b_reg[k];
        end
    end

    // ---------------- stage 4: dot product terms, cross operand split in halves
    logic signed [PW-1:0] dot_a [4][3];
    logic signed [E-1:0]  dot_b [4][3];
    logic signed [DW-1:0] lo_reg [4][3];
    logic signed [DW-1:0] hi_reg [4][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dot_a[DOT_DET][k] = s1_reg[k];
            dot_b[DOT_DET][k] = e1_c_reg[k];
            dot_a[DOT_N1][k]  = s1_reg[k];
            dot_b[DOT_N1][k]  = q_c_reg[k];
            dot_a[DOT_N2][k]  = s2_reg[k];
            dot_b[DOT_N2][k]  = dir_e[k];
            dot_a[DOT_NT][k]  = s2_reg[k];
            dot_b[DOT_NT][k]  = e2_c_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[d][k] <= $signed({1'b0, dot_a[d][k][L-1:0]}) * dot_b[d][k];
                hi_reg[d][k] <= $signed(dot_a[d][k][PW-1:L]) * dot_b[d][k];
            end
        end
    end

    // ---------------- stage 5: recombine the halves
    logic signed [DW-1:0] prod_reg [4][3];

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
        begin
            for (int k = 0; k < 3; k++)
                prod_reg[d][k] <= (hi_reg[d][k] <<< L) + lo_reg[d][k];
        end
    end

    // ---------------- stage 6: dot product sums
    logic signed [DW-1:0] dot_reg [4];

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
            dot_reg[d] <= prod_reg[d][0] + prod_reg[d][1] + prod_reg[d][2];
    end

    // ---------------- stage 7: make the determinant positive
    logic signed [DW-1:0] nrm_reg [4];
    logic                 det_nz_reg;
    logic                 det_neg;

    assign det_neg = dot_reg[DOT_DET][DW-1];

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < 4; d++)
            nrm_reg[d] <= det_neg ? -dot_reg[d] : dot_reg[d];
        det_nz_reg <= (dot_reg[DOT_DET] != '0);
    end

    // ---------------- stage 8: weight tests and divider operands
    logic signed [DW:0]   wsum;
    logic                 pre_hit_next;
    logic                 t_neg_next;
    logic signed [DW-1:0] t_mag;
    logic [NW-1:0]        num_t_reg;
    logic [NW-1:0]        num_1_reg;
    logic [NW-1:0]        num_2_reg;
    logic [DW-1:0]        den_reg;
    rth_side_t            side8_reg;

    always_comb
    begin
        wsum = (DW+1)'(nrm_reg[DOT_N1]) + (DW+1)'(nrm_reg[DOT_N2]);
        pre_hit_next = det_nz_reg
                    && !nrm_reg[DOT_N1][DW-1]
                    && (nrm_reg[DOT_N1] <= nrm_reg[DOT_DET])
                    && !nrm_reg[DOT_N2][DW-1]
                    && (wsum <= (DW+1)'(nrm_reg[DOT_DET]));
        t_neg_next = nrm_reg[DOT_NT][DW-1];
        t_mag      = t_neg_next ? -nrm_reg[DOT_NT] : nrm_reg[DOT_NT];
    end

    always_ff @(posedge clk)
    begin
        num_t_reg <= NW'(unsigned'(t_mag)) << FRAC_BITS;
        num_1_reg <= nrm_reg[DOT_N1][DW-1] ? '0
                   : NW'(unsigned'(nrm_reg[DOT_N1])) << WEIGHT_FRAC;
        num_2_reg <= nrm_reg[DOT_N2][DW-1] ? '0
                   : NW'(unsigned'(nrm_reg[DOT_N2])) << WEIGHT_FRAC;
        den_reg   <= unsigned'(nrm_reg[DOT_DET]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side8_reg <= '0;
        else
        begin
            side8_reg.valid   <= vld_reg[6];
            side8_reg.pre_hit <= pre_hit_next;
            side8_reg.t_neg   <= t_neg_next;
        end
    end

    // ---------------- divider lanes
    logic [DIVQ-1:0] quo_t;
    logic [DIVQ-1:0] quo_1;
    logic [DIVQ-1:0] quo_2;
    rth_div_stat_t   stat_t;
    rth_div_stat_t   stat_1;
    rth_div_stat_t   stat_2;

    rth_div #(.NW(NW), .DW(DW), .QB(DIVQ)) u_div_t
    (
        .clk  (clk),
        .num  (num_t_reg),
        .den  (den_reg),
        .quo  (quo_t),
        .stat (stat_t)
    );

    rth_div #(.NW(NW), .DW(DW), .QB(DIVQ)) u_div_1
    (
        .clk  (clk),
        .num  (num_1_reg),
        .den  (den_reg),
        .quo  (quo_1),
        .stat (stat_1)
    );

    rth_div #(.NW(NW), .DW(DW), .QB(DIVQ)) u_div_2
    (
        .clk  (clk),
        .num  (num_2_reg),
        .den  (den_reg),
        .quo  (quo_2),
        .stat (stat_2)
    );

    // control bits delayed alongside the dividers
    rth_side_t side_reg [DIVQ];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIVQ; s++)
                side_reg[s] <= '0;
        end
        else
        begin
            side_reg[0] <= side8_reg;
            for (int s = 1; s < DIVQ; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // ---------------- distance window test and output register
    rth_side_t            side_out;
    logic signed [TW-1:0] t_q;
    logic signed [TW-1:0] t_rnz;
    logic signed [TW-1:0] t_floor;
    logic signed [TW-1:0] t_ceil;
    logic signed [TW-1:0] t_trunc;
    logic                 hit_next;

    assign side_out = side_reg[DIVQ-1];

    always_comb
    begin
        t_q   = $signed({2'b00, quo_t});
        t_rnz = $signed({{(TW-1){1'b0}}, stat_t.rem_nz});
        if (side_out.t_neg)
        begin
            t_trunc = -t_q;
            t_ceil  = -t_q;
            t_floor = -t_q - t_rnz;
        end
        else
        begin
            t_trunc = t_q;
            t_floor = t_q;
            t_ceil  = t_q + t_rnz;
        end
        hit_next = side_out.valid && side_out.pre_hit
                && !stat_t.ovf && !stat_1.ovf && !stat_2.ovf
                && (t_floor >= TW'(min_distance_reg))
                && (t_ceil <= TW'(max_distance_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
            hit  <= 1'b0;
        end
        else
        begin
            done <= side_out.valid;
            hit  <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        distance   <= hit_next ? t_trunc[C-1:0] : '0;
        weight_one <= hit_next ? quo_1[WEIGHT_BITS-1:0] : '0;
        weight_two <= hit_next ? quo_2[WEIGHT_BITS-1:0] : '0;
    end

endmodule

`default_nettype wire

/* rtl/rth_checker.sv */
// rth_checker: port-level assertions for ray_triangle_hit_test, with bind
// depends on rth_pkg
`default_nettype none

module rth_checker
    import rth_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
)
(
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         busy,
    input wire logic                         done,
    input wire logic                         hit,
    input wire logic signed [COORD_BITS-1:0] distance,
    input wire logic        [WEIGHT_BITS-1:0] weight_one,
    input wire logic        [WEIGHT_BITS-1:0] weight_two
);

    // the pipeline never holds off a triangle
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // hit only appears on a result strobe
    a_hit_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> done)
        else $error("hit without done");

    // a miss carries all-zero payload
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !hit) |-> (distance == '0 && weight_one == '0 && weight_two == '0))
        else $error("miss with nonzero payload");

    // truncated weights of a hit never sum past 1.0
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        hit |-> (({1'b0, weight_one} + {1'b0, weight_two}) <= {1'b0, WEIGHT_ONE}))
        else $error("weight sum above one");

endmodule

bind ray_triangle_hit_test rth_checker #(.COORD_BITS(COORD_BITS)) u_rth_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .done       (done),
    .hit        (hit),
    .distance   (distance),
    .weight_one (weight_one),
    .weight_two (weight_two)
);

`default_nettype wire
